### hw/rtl/pet_pkg.sv
// Shared types and constants for the periodic event table.
package pet_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REBUILD,
    ST_EMIT
  } state_t;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_ONCE = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_RUN  = 2'd3;

  localparam int MAX_RES = 16;
  localparam int RES_IW  = $clog2(MAX_RES);
  localparam int RES_CW  = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [15:0] handler;
    logic [15:0] arg;
    logic [31:0] due;
    logic [15:0] period;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0]  slot;
    logic        ok;
    logic [15:0] handler;
    logic [15:0] arg;
  } result_t;

endpackage

### hw/rtl/pet_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/pet_alu.sv
// Shared saturating adder and unsigned comparator used by the slot scan.
module pet_alu (
  input  logic [31:0] add_a,
  input  logic [15:0] add_b,
  input  logic [31:0] cmp_a,
  input  logic [31:0] cmp_b,
  output logic [31:0] sum,
  output logic        lt
);

  logic [32:0] raw;

  assign raw = {1'b0, add_a} + {17'd0, add_b};
  assign sum = raw[32] ? 32'hFFFF_FFFF : raw[31:0];
  assign lt  = cmp_a < cmp_b;

endmodule

### hw/rtl/periodic_event_table_top.sv
// Periodic event table: add, delete and run of timed events over a slot RAM.
// One word in is accepted, then the slots are scanned (the scan stops early
// at the first free slot for an add, the first match for a delete, or the
// sixteenth firing for a run), then a rebuild scan of all slots follows
// when the earliest-due cache was invalidated, and then the result words
// are sent, held back while out_stall is set. The single slot RAM is read
// one entry per cycle through one shared adder and comparator. Results of a
// step are held in a small buffer and carry the cache value after the whole
// step; the last one has last set.
module periodic_event_table_top import pet_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] now,
  input  logic [15:0] handler_id,
  input  logic [15:0] arg_tag,
  input  logic [15:0] interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  slot,
  output logic        ok,
  output logic [15:0] fired_handler,
  output logic [15:0] fired_arg,
  output logic [31:0] next_due,
  output logic        next_due_valid,
  output logic        last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;

  logic [1:0]  mode_r;
  logic [31:0] now_r;
  logic [15:0] hid_r;
  logic [15:0] tag_r;
  logic [15:0] ivl_r;

  logic [SLOTS-1:0] active;
  logic [CW-1:0]    rd_cnt;
  logic             p_valid;
  logic [IW-1:0]    p_idx;
  logic [31:0]      cache;
  logic             cache_valid;

  result_t           res_buf [MAX_RES];
  logic [RES_CW-1:0] res_cnt;
  logic [RES_IW-1:0] emit_idx;

  logic [ENTRY_W-1:0] ram_rdata_raw;
  entry_t             ram_rdata;
  entry_t             ram_wdata;
  logic               ram_we;

  logic [31:0] alu_sum;
  logic [15:0] alu_add_b;
  logic [31:0] alu_cmp_a;
  logic [31:0] alu_cmp_b;
  logic        alu_lt;

  logic    issue;
  logic    p_last;
  logic    act;
  logic    scan_ok;
  logic    m_add;
  logic    m_del;
  logic    m_run;
  logic    rec;
  logic    stop;
  logic    scan_end;
  logic    cv_next;
  logic    buf_we;
  result_t buf_data;
  logic    reb_take;
  logic    ld;
  logic    emit_last;

  assign ram_rdata = entry_t'(ram_rdata_raw);

  pet_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(p_idx),
    .wdata(ram_wdata),
    .raddr(rd_cnt[IW-1:0]),
    .rdata(ram_rdata_raw)
  );

  pet_alu u_alu (
    .add_a(now_r),
    .add_b(alu_add_b),
    .cmp_a(alu_cmp_a),
    .cmp_b(alu_cmp_b),
    .sum  (alu_sum),
    .lt   (alu_lt)
  );

  assign alu_add_b = (mode_r == MODE_RUN) ? ram_rdata.period : ivl_r;

  always_comb begin
    if (state == ST_SCAN && mode_r == MODE_RUN) begin
      alu_cmp_a = now_r;
      alu_cmp_b = ram_rdata.due;
    end else if (state == ST_SCAN) begin
      alu_cmp_a = alu_sum;
      alu_cmp_b = cache;
    end else begin
      alu_cmp_a = ram_rdata.due;
      alu_cmp_b = cache;
    end
  end

  assign issue  = (state == ST_SCAN || state == ST_REBUILD) && (rd_cnt < CW'(SLOTS));
  assign p_last = p_idx == IW'(SLOTS - 1);
  assign act    = active[p_idx];

  assign scan_ok  = (state == ST_SCAN) && p_valid;
  assign m_add    = scan_ok && (mode_r == MODE_ADD || mode_r == MODE_ONCE) && !act;
  assign m_del    = scan_ok && (mode_r == MODE_DEL) && act &&
                    ram_rdata.handler == hid_r && ram_rdata.arg == tag_r;
  assign m_run    = scan_ok && (mode_r == MODE_RUN) && act && !alu_lt;
  assign rec      = m_add || m_del || m_run;
  assign stop     = rec && (mode_r != MODE_RUN || res_cnt == RES_CW'(MAX_RES - 1));
  assign scan_end = stop || (scan_ok && p_last);
  assign cv_next  = m_run ? 1'b0 : (m_add ? 1'b1 : cache_valid);

  assign buf_we = rec || (scan_end && res_cnt == '0);

  always_comb begin
    buf_data = '0;
    if (rec) begin
      buf_data.slot = 4'(p_idx);
      buf_data.ok   = 1'b1;
      if (m_run) begin
        buf_data.handler = ram_rdata.handler;
        buf_data.arg     = ram_rdata.arg;
      end
    end
  end

  always_comb begin
    ram_we    = m_add || (m_run && ram_rdata.period != '0);
    ram_wdata = ram_rdata;
    ram_wdata.due = alu_sum;
    if (m_add) begin
      ram_wdata.handler = hid_r;
      ram_wdata.arg     = tag_r;
      ram_wdata.period  = (mode_r == MODE_ADD) ? ivl_r : 16'd0;
    end
  end

  assign reb_take  = (state == ST_REBUILD) && p_valid && act && (!cache_valid || alu_lt);
  assign ld        = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign emit_last = {1'b0, emit_idx} == res_cnt - RES_CW'(1);

  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = cv_next ? ST_EMIT : ST_REBUILD;
        end
      end
      ST_REBUILD: begin
        if (p_valid && p_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ld && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      cache       <= '0;
      cache_valid <= 1'b0;
      rd_cnt      <= '0;
      p_valid     <= 1'b0;
      res_cnt     <= '0;
      emit_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r   <= mode;
            now_r    <= now;
            hid_r    <= handler_id;
            tag_r    <= arg_tag;
            ivl_r    <= interval;
            rd_cnt   <= '0;
            p_valid  <= 1'b0;
            res_cnt  <= '0;
            emit_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            rd_cnt <= '0;
          end else if (issue) begin
            rd_cnt <= rd_cnt + CW'(1);
          end
          p_valid <= issue && !scan_end;
          p_idx   <= rd_cnt[IW-1:0];
          if (buf_we) begin
            res_buf[res_cnt[RES_IW-1:0]] <= buf_data;
            res_cnt <= res_cnt + RES_CW'(1);
          end
          if (m_add) begin
            active[p_idx] <= 1'b1;
          end
          if (m_del || (m_run && ram_rdata.period == '0)) begin
            active[p_idx] <= 1'b0;
          end
          if (m_add && (!cache_valid || alu_lt)) begin
            cache       <= alu_sum;
            cache_valid <= 1'b1;
          end
          if (m_run) begin
            cache_valid <= 1'b0;
          end
          if (scan_end && !cv_next) begin
            cache <= '0;
          end
        end
        ST_REBUILD: begin
          if (issue) begin
            rd_cnt <= rd_cnt + CW'(1);
          end
          p_valid <= issue;
          p_idx   <= rd_cnt[IW-1:0];
          if (reb_take) begin
            cache       <= ram_rdata.due;
            cache_valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          p_valid <= 1'b0;
          if (ld) begin
            emit_idx <= emit_idx + RES_IW'(1);
          end
        end
        default: p_valid <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      slot           <= res_buf[emit_idx].slot;
      ok             <= res_buf[emit_idx].ok;
      fired_handler  <= res_buf[emit_idx].handler;
      fired_arg      <= res_buf[emit_idx].arg;
      next_due       <= cache_valid ? cache : 32'd0;
      next_due_valid <= cache_valid;
      last           <= emit_last;
    end
  end

  a_res_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CW'(MAX_RES))
    else $error("result count exceeds buffer depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> res_cnt != '0)
    else $error("emit with empty result buffer");

  a_due_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !next_due_valid) |-> next_due == 32'd0)
    else $error("next_due nonzero without a valid earliest time");

  a_scan_to_emit_cache: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && state_next == ST_EMIT) |=> cache_valid)
    else $error("emit entered straight from scan with invalid cache");

endmodule
